[rtl/dbpc_pkg.sv]
// Shared types and constants for the depth buffer point culler.
// Used by the front end, back end, top level and testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dbpc_pkg;

    localparam int MAP_CELLS  = 32768;
    localparam int MAP_AW     = $clog2(MAP_CELLS);
    localparam int MAX_POINTS = 65536;
    localparam int LIST_AW    = $clog2(MAX_POINTS);
    localparam int CNT_W      = LIST_AW + 1;

    localparam int COORD_W  = 20;
    localparam int DIST_W   = 20;
    localparam int IDX_W    = 20;
    localparam int LIST_W   = IDX_W + DIST_W + MAP_AW;
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 24;

    localparam logic [DIST_W-1:0] DEPTH_ALL_ONES = '1;

    // request codes on s_tuser
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // job kinds after classification
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_ADD   = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_DEPTH_TEST = 3'd0;
    localparam logic [2:0] CFG_FACTOR     = 3'd1;
    localparam logic [2:0] CFG_MAP_COLS   = 3'd2;
    localparam logic [2:0] CFG_MAP_ROWS   = 3'd3;
    localparam logic [2:0] CFG_TOLERANCE  = 3'd4;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] pixel_u;
        logic signed [COORD_W-1:0] pixel_v;
        logic [IDX_W-1:0]          point_index;
    } job_t;

    typedef struct packed {
        logic        depth_test_on;
        logic [6:0]  cell_factor;
        logic [8:0]  map_cols;
        logic [7:0]  map_rows;
        logic [15:0] tolerance_mm;
    } cfg_t;

    typedef struct packed {
        logic             overflow;
        logic             list_end;
        logic [IDX_W-1:0] visible_index;
        logic             has_point;
        logic             accepted;
    } result_t;

endpackage

`default_nettype wire

[rtl/dbpc_ram.sv]
// Generic single write port, single read port RAM with registered read.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module dbpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/dbpc_front.sv]
// Front end: accepts request items, classifies them and queues them.
// Depends on dbpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbpc_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dbpc_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [1:0]                    s_tuser,
    output dbpc_pkg::job_t                     job,
    output logic                               job_valid,
    input  wire logic                          job_pop
);

    dbpc_pkg::job_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    dbpc_pkg::job_t in_job;
    logic           push;

    always_comb begin
        in_job.pos_x       = s_tdata[19:0];
        in_job.pos_y       = s_tdata[39:20];
        in_job.pos_z       = s_tdata[59:40];
        in_job.pixel_u     = s_tdata[79:60];
        in_job.pixel_v     = s_tdata[99:80];
        in_job.point_index = s_tdata[119:100];
        unique case (s_tuser)
            dbpc_pkg::REQ_START: in_job.kind = dbpc_pkg::KIND_START;
            // a point behind the camera is passed on as KIND_NONE and never added to the list
            dbpc_pkg::REQ_ADD:   in_job.kind = s_tdata[59] ? dbpc_pkg::KIND_NONE
                                                           : dbpc_pkg::KIND_ADD;
            dbpc_pkg::REQ_READ:  in_job.kind = dbpc_pkg::KIND_READ;
            default:             in_job.kind = dbpc_pkg::KIND_NONE;
        endcase
    end

    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = job_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(job_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            q_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

`default_nettype wire

[rtl/dbpc_back.sv]
// Back end: runs queued jobs one at a time against the depth map and list.
// Depends on dbpc_pkg and dbpc_ram.
`timescale 1ns / 1ps
`default_nettype none

module dbpc_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dbpc_pkg::cfg_t                cfg,
    input  wire dbpc_pkg::job_t                job,
    input  wire logic                          job_valid,
    output logic                               job_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [dbpc_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_MAPRD = 4'd5;
    localparam logic [3:0] S_MAPWR = 4'd6;
    localparam logic [3:0] S_RD0   = 4'd7;
    localparam logic [3:0] S_RD1   = 4'd8;
    localparam logic [3:0] S_RD2   = 4'd9;

    localparam int DW = dbpc_pkg::DIST_W;
    localparam int AW = dbpc_pkg::MAP_AW;
    localparam int COORD_SEL_W = dbpc_pkg::COORD_W;

    logic [3:0]                     state_reg, state_next;
    logic [4:0]                     step_reg, step_next;
    logic [AW-1:0]                  clr_reg, clr_next;
    logic [dbpc_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [dbpc_pkg::CNT_W-1:0]     rdptr_reg, rdptr_next;
    logic                           ovf_reg, ovf_next;
    logic                           out_valid_reg, out_valid_next;
    dbpc_pkg::result_t              out_reg, out_next;

    dbpc_pkg::job_t                 job_reg, job_next;
    logic [15:0]                    num_u_reg, num_u_next, num_v_reg, num_v_next;
    logic [6:0]                     rem_u_reg, rem_u_next, rem_v_reg, rem_v_next;
    logic [39:0]                    prod_reg, acc_reg, acc_next;
    logic [39:0]                    rad_reg, rad_next;
    logic [21:0]                    rem_s_reg, rem_s_next;
    logic [DW-1:0]                  root_reg, root_next;
    logic [AW-1:0]                  addr_reg, addr_next;
    logic [dbpc_pkg::LIST_W-1:0]    ent_reg, ent_next;

    logic                           map_we;
    logic [AW-1:0]                  map_wa, map_ra;
    logic [DW-1:0]                  map_wd, map_rd;
    logic                           list_we;
    logic [dbpc_pkg::LIST_W-1:0]    list_wd, list_rd;

    logic [6:0]                     f_eff;
    logic [8:0]                     cols_eff;
    logic [7:0]                     rows_eff;
    logic [7:0]                     t_u, t_v;
    logic signed [COORD_SEL_W-1:0]  sq_sel;
    logic signed [39:0]             sq_full;
    logic [23:0]                    t_s, trial_s;
    logic [19:0]                    abs_u, abs_v;
    logic                           cell_bad;
    logic [20:0]                    limit;
    logic                           can_pop;

    assign f_eff    = (cfg.cell_factor == 7'd0) ? 7'd1 : cfg.cell_factor;
    assign cols_eff = (cfg.map_cols > 9'd256) ? 9'd256 : cfg.map_cols;
    assign rows_eff = (cfg.map_rows > 8'd128) ? 8'd128 : cfg.map_rows;

    // cell = |pixel| / 16 / factor, truncated toward zero
    assign abs_u = job.pixel_u[19] ? 20'(-job.pixel_u) : job.pixel_u;
    assign abs_v = job.pixel_v[19] ? 20'(-job.pixel_v) : job.pixel_v;

    assign t_u = {rem_u_reg, num_u_reg[15]};
    assign t_v = {rem_v_reg, num_v_reg[15]};

    assign sq_sel  = (step_reg == 5'd0) ? job_reg.pos_x :
                     (step_reg == 5'd1) ? job_reg.pos_y : job_reg.pos_z;
    assign sq_full = sq_sel * sq_sel;

    assign t_s     = {rem_s_reg, rad_reg[39:38]};
    assign trial_s = {2'b00, root_reg, 2'b01};

    // negative pixel with a nonzero quotient means a negative cell
    assign cell_bad = (job_reg.pixel_u[19] && num_u_reg != 16'd0)
                   || (job_reg.pixel_v[19] && num_v_reg != 16'd0)
                   || (num_u_reg >= {7'd0, cols_eff})
                   || (num_v_reg >= {8'd0, rows_eff});

    assign limit   = {1'b0, map_rd} + {5'd0, cfg.tolerance_mm};
    assign can_pop = !out_valid_reg || m_tready;

    assign map_ra  = (state_reg == S_RD1) ? list_rd[AW-1:0] : addr_reg;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        rdptr_next     = rdptr_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        job_next       = job_reg;
        num_u_next     = num_u_reg;
        num_v_next     = num_v_reg;
        rem_u_next     = rem_u_reg;
        rem_v_next     = rem_v_reg;
        acc_next       = acc_reg;
        rad_next       = rad_reg;
        rem_s_next     = rem_s_reg;
        root_next      = root_reg;
        addr_next      = addr_reg;
        ent_next       = ent_reg;
        job_pop        = 1'b0;
        map_we         = 1'b0;
        map_wa         = addr_reg;
        map_wd         = root_reg;
        list_we        = 1'b0;
        list_wd        = {job_reg.point_index, root_reg, addr_reg};

        unique case (state_reg)
            S_CLEAR: begin
                map_we   = 1'b1;
                map_wa   = clr_reg;
                map_wd   = dbpc_pkg::DEPTH_ALL_ONES;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(dbpc_pkg::MAP_CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (job_valid && can_pop) begin
                    job_pop  = 1'b1;
                    job_next = job;
                    unique case (job.kind)
                        dbpc_pkg::KIND_START: begin
                            count_next     = '0;
                            rdptr_next     = '0;
                            ovf_next       = 1'b0;
                            clr_next       = '0;
                            out_next       = '0;
                            out_valid_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        dbpc_pkg::KIND_ADD: begin
                            num_u_next = abs_u[19:4];
                            num_v_next = abs_v[19:4];
                            rem_u_next = '0;
                            rem_v_next = '0;
                            acc_next   = '0;
                            step_next  = '0;
                            state_next = S_DIV;
                        end
                        dbpc_pkg::KIND_READ: begin
                            state_next = S_RD0;
                        end
                        default: begin
                            out_next          = '0;
                            out_next.overflow = ovf_reg;
                            out_valid_next    = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle on both axes
                if (t_u >= {1'b0, f_eff}) begin
                    rem_u_next = 7'(t_u - {1'b0, f_eff});
                    num_u_next = {num_u_reg[14:0], 1'b1};
                end else begin
                    rem_u_next = t_u[6:0];
                    num_u_next = {num_u_reg[14:0], 1'b0};
                end
                if (t_v >= {1'b0, f_eff}) begin
                    rem_v_next = 7'(t_v - {1'b0, f_eff});
                    num_v_next = {num_v_reg[14:0], 1'b1};
                end else begin
                    rem_v_next = t_v[6:0];
                    num_v_next = {num_v_reg[14:0], 1'b0};
                end
                // squares of x, y, z are summed in the cycle after the multiplier forms them
                if (step_reg >= 5'd1 && step_reg <= 5'd3) begin
                    acc_next = acc_reg + prod_reg;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd15) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                out_next = '0;
                if (cell_bad) begin
                    out_next.overflow = ovf_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end else if (count_reg == dbpc_pkg::CNT_W'(dbpc_pkg::MAX_POINTS)) begin
                    ovf_next          = 1'b1;
                    out_next.overflow = 1'b1;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end else begin
                    // row < 128 and col < 256, so the address always fits the map
                    addr_next  = {8'd0, num_v_reg[6:0]} * {6'd0, cols_eff}
                               + {7'd0, num_u_reg[7:0]};
                    rad_next   = acc_reg;
                    rem_s_next = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (t_s >= trial_s) begin
                    rem_s_next = 22'(t_s - trial_s);
                    root_next  = {root_reg[DW-2:0], 1'b1};
                end else begin
                    rem_s_next = t_s[21:0];
                    root_next  = {root_reg[DW-2:0], 1'b0};
                end
                rad_next  = {rad_reg[37:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == 5'(DW - 1)) begin
                    state_next = S_MAPRD;
                end
            end
            S_MAPRD: begin
                state_next = S_MAPWR;
            end
            S_MAPWR: begin
                map_we            = cfg.depth_test_on && (root_reg <= map_rd);
                list_we           = 1'b1;
                count_next        = count_reg + 1'b1;
                out_next          = '0;
                out_next.accepted = 1'b1;
                out_next.overflow = ovf_reg;
                out_valid_next    = 1'b1;
                state_next        = S_IDLE;
            end
            S_RD0: begin
                if (rdptr_reg >= count_reg) begin
                    out_next          = '0;
                    out_next.list_end = 1'b1;
                    out_next.overflow = ovf_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end else begin
                    rdptr_next = rdptr_reg + 1'b1;
                    state_next = S_RD1;
                end
            end
            S_RD1: begin
                ent_next = list_rd;
                if (!cfg.depth_test_on) begin
                    out_next               = '0;
                    out_next.has_point     = 1'b1;
                    out_next.visible_index = list_rd[dbpc_pkg::LIST_W-1 -: dbpc_pkg::IDX_W];
                    out_next.overflow      = ovf_reg;
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end else begin
                    state_next = S_RD2;
                end
            end
            S_RD2: begin
                if ({1'b0, ent_reg[AW +: DW]} <= limit) begin
                    out_next               = '0;
                    out_next.has_point     = 1'b1;
                    out_next.visible_index = ent_reg[dbpc_pkg::LIST_W-1 -: dbpc_pkg::IDX_W];
                    out_next.overflow      = ovf_reg;
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end else begin
                    // skip a hidden entry
                    state_next = S_RD0;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            step_reg      <= '0;
            clr_reg       <= '0;
            count_reg     <= '0;
            rdptr_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            rdptr_reg     <= rdptr_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg   <= out_next;
        job_reg   <= job_next;
        num_u_reg <= num_u_next;
        num_v_reg <= num_v_next;
        rem_u_reg <= rem_u_next;
        rem_v_reg <= rem_v_next;
        prod_reg  <= 40'(sq_full);
        acc_reg   <= acc_next;
        rad_reg   <= rad_next;
        rem_s_reg <= rem_s_next;
        root_reg  <= root_next;
        addr_reg  <= addr_next;
        ent_reg   <= ent_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    dbpc_ram #(
        .WIDTH (DW),
        .DEPTH (dbpc_pkg::MAP_CELLS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (map_we),
        .wr_addr (map_wa),
        .wr_data (map_wd),
        .rd_addr (map_ra),
        .rd_data (map_rd)
    );

    dbpc_ram #(
        .WIDTH (dbpc_pkg::LIST_W),
        .DEPTH (dbpc_pkg::MAX_POINTS)
    ) u_list (
        .aclk    (aclk),
        .wr_en   (list_we),
        .wr_addr (count_reg[dbpc_pkg::LIST_AW-1:0]),
        .wr_data (list_wd),
        .rd_addr (rdptr_reg[dbpc_pkg::LIST_AW-1:0]),
        .rd_data (list_rd)
    );

endmodule

`default_nettype wire

[rtl/depth_buffer_point_culler.sv]
// Top level of the depth buffer point culler: configuration registers,
// front end queue and back end engine. Depends on dbpc_pkg, dbpc_front, dbpc_back.
//
//   channel  | ports                       | carries
//   ---------+-----------------------------+---------------------------------
//   request  | s_tvalid s_tready s_tdata   | start / add point / read next
//            | s_tuser                     |
//   result   | m_tvalid m_tready m_tdata   | one result item per request
//   config   | cfg_wr_en cfg_wr_index/data | register writes, no read-back
//
// Add point: 16 division steps, 20 square root steps, then a map
// read-modify-write. Read: each list entry examined needs a list memory
// read and, with the depth test on, a map memory read. Start and reset each
// run a clearing pass over all 32768 map cells during which no new job starts.
// Requests queue two deep in front of the engine; a held result stalls the
// next job, and input stalls once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module depth_buffer_point_culler (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, pos_z, pixel_u, pixel_v, point_index (20 bits each)
    input  wire logic [119:0] s_tdata,
    // req_type
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // accepted, has_point, visible_index[19:0], list_end, overflow
    output logic [23:0]       m_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_wr_index,
    input  wire logic [15:0]  cfg_wr_data
);

    dbpc_pkg::cfg_t cfg_reg;
    dbpc_pkg::job_t job;
    logic           job_valid;
    logic           job_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.depth_test_on <= 1'b1;
            cfg_reg.cell_factor   <= 7'd14;
            cfg_reg.map_cols      <= 9'd45;
            cfg_reg.map_rows      <= 8'd34;
            cfg_reg.tolerance_mm  <= 16'd50;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                dbpc_pkg::CFG_DEPTH_TEST: cfg_reg.depth_test_on <= cfg_wr_data[0];
                dbpc_pkg::CFG_FACTOR:     cfg_reg.cell_factor   <= cfg_wr_data[6:0];
                dbpc_pkg::CFG_MAP_COLS:   cfg_reg.map_cols      <= cfg_wr_data[8:0];
                dbpc_pkg::CFG_MAP_ROWS:   cfg_reg.map_rows      <= cfg_wr_data[7:0];
                dbpc_pkg::CFG_TOLERANCE:  cfg_reg.tolerance_mm  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    dbpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop)
    );

    dbpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/dbpc_checker.sv]
// Port-level checks for the depth buffer point culler, bound to the top level.
// Depends on depth_buffer_point_culler.
`timescale 1ns / 1ps
`default_nettype none

module dbpc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // result leaves reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // at most one of accepted, has_point, list_end per result
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0({m_tdata[0], m_tdata[1], m_tdata[22]}))
        else $error("result marks more than one outcome");

    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[21:2] == 20'd0)
        else $error("index without a returned point");

endmodule

bind depth_buffer_point_culler dbpc_checker u_dbpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for depth_buffer_point_culler: a scoreboard class
// predicts every result item from the accepted requests; tasks drive the ports.
// Depends on rtl/dbpc_pkg.sv and rtl/depth_buffer_point_culler.sv.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int IDLE_LIMIT = 150000;
    localparam int NUM_PHASES = 8;
    localparam int RAND_PER_PHASE = 160;

    class cull_scoreboard;
        logic [dbpc_pkg::DIST_W-1:0] depth_map [dbpc_pkg::MAP_CELLS];
        logic [dbpc_pkg::IDX_W-1:0]  surv_index [dbpc_pkg::MAX_POINTS];
        logic [dbpc_pkg::DIST_W-1:0] surv_dist [dbpc_pkg::MAX_POINTS];
        int unsigned                 surv_cell [dbpc_pkg::MAX_POINTS];
        int unsigned                 list_count;
        int unsigned                 read_ptr;
        bit                          overflow_seen;
        bit                          depth_test;
        int unsigned                 factor, cols, rows, tolerance;
        dbpc_pkg::result_t           expected_q [$];
        int                          errors;

        function new();
            depth_test = 1;
            factor = 14;
            cols = 45;
            rows = 34;
            tolerance = 50;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (depth_map[i]) depth_map[i] = dbpc_pkg::DEPTH_ALL_ONES;
            list_count = 0;
            read_ptr = 0;
            overflow_seen = 0;
        endfunction

        function void set_reg(logic [2:0] index, logic [15:0] value);
            case (index)
                dbpc_pkg::CFG_DEPTH_TEST: depth_test = value[0];
                dbpc_pkg::CFG_FACTOR:     factor = 32'(value[6:0]);
                dbpc_pkg::CFG_MAP_COLS:   cols = 32'(value[8:0]);
                dbpc_pkg::CFG_MAP_ROWS:   rows = 32'(value[7:0]);
                dbpc_pkg::CFG_TOLERANCE:  tolerance = 32'(value);
                default: ;
            endcase
        endfunction

        function int eff_factor();
            return (factor == 0) ? 1 : int'(factor);
        endfunction
        function int eff_cols();
            return (cols > 256) ? 256 : int'(cols);
        endfunction
        function int eff_rows();
            return (rows > 128) ? 128 : int'(rows);
        endfunction

        function logic [dbpc_pkg::DIST_W-1:0] root_down(longint unsigned v);
            logic [dbpc_pkg::DIST_W-1:0] r;
            logic [dbpc_pkg::DIST_W-1:0] trial;
            r = '0;
            for (int b = dbpc_pkg::DIST_W - 1; b >= 0; b--) begin
                trial = r | (20'd1 << b);
                if (longint'(trial) * longint'(trial) <= v) r = trial;
            end
            return r;
        endfunction

        function bit add_point(logic signed [19:0] x, y, z, u, v, logic [19:0] idx);
            longint col, row, addr, f, sq;
            logic [dbpc_pkg::DIST_W-1:0] dist_mm;
            if (z < 0) return 0;
            f = 16 * eff_factor();
            col = longint'(u) / f;
            row = longint'(v) / f;
            if (col < 0 || col >= eff_cols() || row < 0 || row >= eff_rows()) return 0;
            addr = row * eff_cols() + col;
            if (addr >= dbpc_pkg::MAP_CELLS) return 0;
            if (list_count >= dbpc_pkg::MAX_POINTS) begin
                overflow_seen = 1;
                return 0;
            end
            sq = longint'(x) * x + longint'(y) * y + longint'(z) * z;
            dist_mm = root_down(sq);
            surv_index[list_count] = idx;
            surv_dist[list_count] = dist_mm;
            surv_cell[list_count] = 32'(addr);
            list_count++;
            if (depth_test && dist_mm <= depth_map[addr]) depth_map[addr] = dist_mm;
            return 1;
        endfunction

        function void note_input(logic [1:0] req, logic signed [19:0] x, y, z, u, v,
                                 logic [19:0] idx);
            dbpc_pkg::result_t r;
            int unsigned p;
            r = '0;
            case (req)
                dbpc_pkg::REQ_START: clear_frame();
                dbpc_pkg::REQ_ADD:   r.accepted = add_point(x, y, z, u, v, idx);
                dbpc_pkg::REQ_READ: begin
                    while (read_ptr < list_count && !r.has_point) begin
                        p = read_ptr;
                        read_ptr = read_ptr + 1;
                        if (!depth_test || longint'(surv_dist[p]) <=
                                longint'(depth_map[surv_cell[p]]) + longint'(tolerance)) begin
                            r.has_point = 1;
                            r.visible_index = surv_index[p];
                        end
                    end
                    r.list_end = !r.has_point;
                end
                default: ;
            endcase
            r.overflow = overflow_seen;
            expected_q = {expected_q, r};
        endfunction

        task report(string what, logic [23:0] got, logic [23:0] want);
            errors++;
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        endtask

        task check(logic [23:0] data);
            dbpc_pkg::result_t got, want;
            got = data;
            if (expected_q.size() == 0) begin
                report("unexpected item", data, '0);
                return;
            end
            want = expected_q.pop_front();
            if (got.accepted != want.accepted) report("accepted", got, want);
            if (got.has_point != want.has_point) report("has_point", got, want);
            if (got.visible_index != want.visible_index) report("visible_index", got, want);
            if (got.list_end != want.list_end) report("list_end", got, want);
            if (got.overflow != want.overflow) report("overflow", got, want);
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;
    logic         cfg_wr_en;
    logic [2:0]   cfg_wr_index;
    logic [15:0]  cfg_wr_data;

    cull_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    depth_buffer_point_culler u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // result side: check accepted items, then choose the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task send(logic [1:0] req, logic signed [19:0] x, y, z, u, v, logic [19:0] idx);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= {idx, v, u, z, y, x};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(req, x, y, z, u, v, idx);
    endtask

    // hold the request side until every expected item has come back
    task drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // leaves the write enable high; write_all drops it after the last write
    task write_reg(logic [2:0] index, logic [15:0] value);
        cfg_wr_en <= 1;
        cfg_wr_index <= index;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.set_reg(index, value);
    endtask

    task write_all(bit t, int f, int c, int r, int tol);
        write_reg(dbpc_pkg::CFG_DEPTH_TEST, {15'd0, t});
        write_reg(dbpc_pkg::CFG_FACTOR, 16'(f));
        write_reg(dbpc_pkg::CFG_MAP_COLS, 16'(c));
        write_reg(dbpc_pkg::CFG_MAP_ROWS, 16'(r));
        write_reg(dbpc_pkg::CFG_TOLERANCE, 16'(tol));
        cfg_wr_en <= 0;
    endtask

    task random_item();
        logic signed [19:0] x, y, z, u, v;
        logic [19:0] idx;
        int pick, span_u, span_v;
        pick = $urandom_range(0, 99);
        idx = 20'($urandom);
        span_u = 16 * sb.eff_factor() * ((sb.eff_cols() == 0) ? 1 : sb.eff_cols());
        span_v = 16 * sb.eff_factor() * ((sb.eff_rows() == 0) ? 1 : sb.eff_rows());
        if ($urandom_range(0, 99) < 15) begin
            x = 20'($urandom);
            y = 20'($urandom);
            z = 20'($urandom);
            u = 20'($urandom);
            v = 20'($urandom);
        end else begin
            x = 20'($signed(20'($urandom_range(0, 6000))) - 3000);
            y = 20'($signed(20'($urandom_range(0, 6000))) - 3000);
            z = 20'($urandom_range(0, 5000));
            if ($urandom_range(0, 99) < 8) z = -z - 20'sd1;
            u = 20'($urandom_range(0, span_u - 1));
            v = 20'($urandom_range(0, span_v - 1));
            case ($urandom_range(0, 9))
                0: u = -$signed(20'($urandom_range(0, 16 * sb.eff_factor() + 20)));
                1: v = 20'(span_v + int'($urandom_range(0, 40)));
                default: ;
            endcase
        end
        if (pick < 58) send(dbpc_pkg::REQ_ADD, x, y, z, u, v, idx);
        else if (pick < 96) send(dbpc_pkg::REQ_READ, x, y, z, u, v, idx);
        else send(REQ_UNKNOWN, x, y, z, u, v, idx);
    endtask

    task directed_items();
        send(dbpc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
        send(dbpc_pkg::REQ_ADD, 100, 0, 0, 0, 0, 20'hFFFFF);
        send(dbpc_pkg::REQ_ADD, 0, 0, -1, 0, 0, 1);
        send(dbpc_pkg::REQ_ADD, 0, 0, 20'sh7FFFF, 16, 16, 2);
        send(dbpc_pkg::REQ_ADD, 20'sh80000, 20'sh80000, 20'sh7FFFF, 100, 100, 3);
        send(dbpc_pkg::REQ_ADD, 20'sh7FFFF, 20'sh7FFFF, 0, 224, 224, 4);
        send(dbpc_pkg::REQ_ADD, 0, 0, 50, -5, -200, 5);
        send(dbpc_pkg::REQ_ADD, 0, 0, 10, 0, 0, 6);
        send(dbpc_pkg::REQ_ADD, 0, 0, 60, -223, 0, 7);
        send(dbpc_pkg::REQ_ADD, 0, 0, 61, -224, 0, 8);
        send(dbpc_pkg::REQ_ADD, 0, 0, 20, 20'(16 * 14 * 45), 0, 9);
        send(dbpc_pkg::REQ_ADD, 0, 0, 20, 20'(16 * 14 * 45 - 1), 20'(16 * 14 * 34 - 1), 10);
        send(dbpc_pkg::REQ_ADD, 0, 0, 20, 0, 20'(16 * 14 * 34), 11);
        send(dbpc_pkg::REQ_ADD, 0, 0, 20, 20'sh7FFFF, 20'sh80000, 12);
        send(REQ_UNKNOWN, 20'sh7FFFF, 1, 1, 1, 1, 20'hFFFFF);
        repeat (8) send(dbpc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
        send(dbpc_pkg::REQ_START, 0, 0, 0, 0, 0, 0);
        send(dbpc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
    endtask

    initial begin
        sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = dbpc_pkg::REQ_START;
        m_tready = 0;
        cfg_wr_en = 0;
        cfg_wr_index = dbpc_pkg::CFG_DEPTH_TEST;
        cfg_wr_data = '0;
        send_idle_pct = 16;
        recv_idle_pct = 84;
        quiet_cycles = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        directed_items();
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: ;
                1: write_all(1, 1, 1, 1, 0);
                2: write_all(0, 64, 256, 128, 65535);
                3: write_all(1, 0, 511, 255, 65535);
                4: write_all(1, 127, 0, 5, 10);
                5: write_all(1, 2, 4, 4, $urandom_range(0, 200));
                default: write_all($urandom_range(0, 1), $urandom_range(1, 64),
                                   $urandom_range(1, 256), $urandom_range(1, 128),
                                   $urandom_range(0, 65535));
            endcase
            send_idle_pct = (ph < 3) ? 16 : (ph < 6) ? 84 : 0;
            recv_idle_pct = (ph < 3) ? 84 : (ph < 6) ? 16 : 0;
            send(dbpc_pkg::REQ_START, 0, 0, 0, 0, 0, 0);
            for (int i = 0; i < RAND_PER_PHASE; i++) random_item();
            repeat (6) send(dbpc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
        end
        drain();
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

[depth_buffer_point_culler.f]
rtl/dbpc_pkg.sv
rtl/dbpc_ram.sv
rtl/dbpc_front.sv
rtl/dbpc_back.sv
rtl/depth_buffer_point_culler.sv
rtl/dbpc_checker.sv
tb/testbench.sv
